// ----- rtl/packet_rate_meter_unit_assert.svh -----
// Assertion macros shared by the checker of this block.
// Both expect aclk and aresetn in scope.
`ifndef PACKET_RATE_METER_UNIT_ASSERT_SVH
`define PACKET_RATE_METER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PRM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define PRM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/prm_pkg.sv -----
package prm_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned BYTE_W = 64;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned LEN_W  = 16;

    localparam logic [KIND_W-1:0] KIND_PACKET    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PKT_RATE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BYTE_RATE = 2'd3;

endpackage

// ----- rtl/packet_rate_meter_unit.sv -----
// Packet and byte rate meter. Each item is a packet event, a clear, a packet-rate
// query or a byte-rate query, and gives one result holding both totals and a rate
// (zero for events and clears). Packet events and clears load their result at the
// edge that accepts them, so they flow one per cycle while the result side keeps up.
// A query first scales the count by TICKS_PER_SECOND (ST_MUL), then runs the radix-2
// restoring divider (ST_DIV, one quotient bit per cycle), then loads the result; for
// counts that would overflow the scaling, the order is divide first and scale after
// (ST_SCALE). The input is not ready while a query is being scaled or divided, or a
// result is held and not taken. ignore_reg is written through cfg_wr_en/cfg_wr_data.
module packet_rate_meter_unit
    import prm_pkg::*;
#(
    parameter int unsigned TICKS_PER_SECOND = 1000
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [DATA_W-1:0] cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [KIND_W-1:0] s_kind,
    input  logic [DATA_W-1:0] s_now_tick,
    input  logic [LEN_W-1:0]  s_packet_length,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_packet_count,
    output logic [BYTE_W-1:0] m_octet_count,
    output logic [DATA_W-1:0] m_rate
);

    localparam logic [DATA_W-1:0] HZ          = DATA_W'(TICKS_PER_SECOND);
    localparam logic [DATA_W-1:0] SMALL_LIMIT =
        DATA_W'(64'hFFFF_FFFF / 64'(TICKS_PER_SECOND));
    localparam int unsigned       CNT_W       = $clog2(DATA_W);
    localparam logic [CNT_W-1:0]  DIV_LAST    = CNT_W'(DATA_W - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_SCALE
    } state_t;

    state_t              state_reg;
    logic [DATA_W-1:0]   ignore_reg;
    logic [DATA_W-1:0]   packet_total_reg;
    logic [BYTE_W-1:0]   byte_total_reg;
    logic [DATA_W-1:0]   first_tick_reg;
    logic [DATA_W-1:0]   last_tick_reg;
    logic                small_reg;
    logic [DATA_W-1:0]   count_reg;
    logic [DATA_W-1:0]   divisor_reg;
    logic [DATA_W-1:0]   dvd_reg;      // dividend in, quotient shifts in from the bottom
    logic [DATA_W-1:0]   rem_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                m_valid_reg;
    logic [DATA_W-1:0]   m_packet_count_reg;
    logic [BYTE_W-1:0]   m_octet_count_reg;
    logic [DATA_W-1:0]   m_rate_reg;

    logic                accept;
    logic                result_load;
    logic [DATA_W-1:0]   first_next;
    logic                counted;
    logic [DATA_W-1:0]   packet_total_next;
    logic [BYTE_W-1:0]   byte_total_next;
    logic [DATA_W-1:0]   elapsed_raw;
    logic [DATA_W-1:0]   elapsed_next;
    logic [DATA_W-1:0]   count_next;
    logic [DATA_W-1:0]   mul_a;
    logic [DATA_W-1:0]   mul_prod;
    logic [DATA_W:0]     rem_shift;
    logic                rem_ge;
    logic [DATA_W-1:0]   rem_next;
    logic [DATA_W-1:0]   dvd_next;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    // a new result is loaded by an event or clear, or at the end of a query
    assign result_load = (accept && ((s_kind == KIND_PACKET) || (s_kind == KIND_CLEAR)))
                       || ((state_reg == ST_DIV) && (cnt_reg == DIV_LAST) && small_reg)
                       || (state_reg == ST_SCALE);

    // packet event bookkeeping; zero first tick means not started
    assign first_next        = (first_tick_reg == '0) ? s_now_tick : first_tick_reg;
    assign counted           = (s_now_tick - first_next) >= ignore_reg;
    assign packet_total_next = counted ? packet_total_reg + 1'b1 : packet_total_reg;
    assign byte_total_next   = counted ? byte_total_reg + BYTE_W'(s_packet_length)
                                       : byte_total_reg;

    assign elapsed_raw  = last_tick_reg - first_tick_reg - ignore_reg;
    assign elapsed_next = (elapsed_raw == '0) ? DATA_W'(1) : elapsed_raw;
    assign count_next   = (s_kind == KIND_PKT_RATE) ? packet_total_reg
                                                    : byte_total_reg[DATA_W-1:0];

    // shared scaling multiplier: count before the divide, quotient after it
    assign mul_a    = (state_reg == ST_SCALE) ? dvd_reg : count_reg;
    assign mul_prod = mul_a * HZ;

    // one restoring divide step
    assign rem_shift = {rem_reg, dvd_reg[DATA_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, divisor_reg};
    assign rem_next  = rem_ge ? DATA_W'(rem_shift - {1'b0, divisor_reg})
                              : rem_shift[DATA_W-1:0];
    assign dvd_next  = {dvd_reg[DATA_W-2:0], rem_ge};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            ignore_reg         <= '0;
            packet_total_reg   <= '0;
            byte_total_reg     <= '0;
            first_tick_reg     <= '0;
            last_tick_reg      <= '0;
            small_reg          <= 1'b0;
            count_reg          <= '0;
            divisor_reg        <= '0;
            dvd_reg            <= '0;
            rem_reg            <= '0;
            cnt_reg            <= '0;
            m_valid_reg        <= 1'b0;
            m_packet_count_reg <= '0;
            m_octet_count_reg  <= '0;
            m_rate_reg         <= '0;
        end else begin
            if (cfg_wr_en) begin
                ignore_reg <= cfg_wr_data;
            end
            if (result_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        case (s_kind)
                            KIND_PACKET: begin
                                first_tick_reg     <= first_next;
                                last_tick_reg      <= s_now_tick;
                                packet_total_reg   <= packet_total_next;
                                byte_total_reg     <= byte_total_next;
                                m_packet_count_reg <= packet_total_next;
                                m_octet_count_reg  <= byte_total_next;
                                m_rate_reg         <= '0;
                            end
                            KIND_CLEAR: begin
                                first_tick_reg     <= '0;
                                last_tick_reg      <= '0;
                                packet_total_reg   <= '0;
                                byte_total_reg     <= '0;
                                m_packet_count_reg <= '0;
                                m_octet_count_reg  <= '0;
                                m_rate_reg         <= '0;
                            end
                            default: begin
                                count_reg   <= count_next;
                                divisor_reg <= elapsed_next;
                                small_reg   <= count_next < SMALL_LIMIT;
                                dvd_reg     <= count_next;
                                rem_reg     <= '0;
                                cnt_reg     <= '0;
                                state_reg   <= (count_next < SMALL_LIMIT) ? ST_MUL : ST_DIV;
                            end
                        endcase
                    end
                end
                ST_MUL: begin
                    dvd_reg   <= mul_prod;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    dvd_reg <= dvd_next;
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == DIV_LAST) begin
                        if (small_reg) begin
                            m_packet_count_reg <= packet_total_reg;
                            m_octet_count_reg  <= byte_total_reg;
                            m_rate_reg         <= dvd_next;
                            state_reg          <= ST_IDLE;
                        end else begin
                            state_reg <= ST_SCALE;
                        end
                    end
                end
                ST_SCALE: begin
                    m_packet_count_reg <= packet_total_reg;
                    m_octet_count_reg  <= byte_total_reg;
                    m_rate_reg         <= mul_prod;
                    state_reg          <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_packet_count = m_packet_count_reg;
    assign m_octet_count  = m_octet_count_reg;
    assign m_rate         = m_rate_reg;

endmodule

// ----- rtl/prm_checker.sv -----
`include "packet_rate_meter_unit_assert.svh"

module prm_checker
    import prm_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic [KIND_W-1:0] s_kind,
    input logic              m_valid,
    input logic              m_ready,
    input logic [DATA_W-1:0] m_packet_count,
    input logic [BYTE_W-1:0] m_octet_count,
    input logic [DATA_W-1:0] m_rate
);

    logic              s_acc;
    logic              is_event;
    logic [KIND_W-1:0] kind_reg;
    logic              is_query;

    assign s_acc    = s_valid && s_ready;
    assign is_event = (s_kind == KIND_PACKET) || (s_kind == KIND_CLEAR);

    // kind of the item whose result is on the output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= KIND_PACKET;
        end else if (s_acc) begin
            kind_reg <= s_kind;
        end
    end

    assign is_query = (kind_reg == KIND_PKT_RATE) || (kind_reg == KIND_BYTE_RATE);

    `PRM_ASSERT_NEXT(a_event_one_cycle, s_acc && is_event, m_valid)
    `PRM_ASSERT_NEXT(a_clear_zeroes, s_acc && (s_kind == KIND_CLEAR),
                     (m_packet_count == '0) && (m_octet_count == '0) && (m_rate == '0))
    `PRM_ASSERT_NOW(a_event_no_rate, m_valid && !is_query, m_rate == '0)
    `PRM_ASSERT_NOW(a_hold_blocks_input, m_valid && !m_ready, !s_ready)
    `PRM_ASSERT_NEXT(a_result_holds, m_valid && !m_ready,
                     m_valid && $stable(m_rate) && $stable(m_octet_count))

endmodule

bind packet_rate_meter_unit prm_checker u_prm_checker (.*);
